@@ sv/trigger_pulse_qualifier_assert.svh @@
// assertion macros used by the checker file
`ifndef TRIGGER_PULSE_QUALIFIER_ASSERT_SVH
`define TRIGGER_PULSE_QUALIFIER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define TPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trigger pulse qualifier check failed");

// next-cycle implication, reset masks the check
`define TPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trigger pulse qualifier check failed");

`endif

@@ sv/tpq_pkg.sv @@
package tpq_pkg;

   // field widths
   localparam int TIME_W   = 32;
   localparam int MS_W     = 16;
   localparam int CH_W     = 2;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 3;

   // configuration register indexes
   localparam logic [INDEX_W-1:0] REG_LEVEL_MODE   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_HOLDOFF_MS   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_LOCKOUT_MS   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_PULSE_MIN_MS = 3'd3;
   localparam logic [INDEX_W-1:0] REG_PULSE_MAX_MS = 3'd4;

   // configuration reset values
   localparam logic [MS_W-1:0] HOLDOFF_RESET   = 16'd2000;
   localparam logic [MS_W-1:0] LOCKOUT_RESET   = 16'd300;
   localparam logic [MS_W-1:0] PULSE_MIN_RESET = 16'd100;
   localparam logic [MS_W-1:0] PULSE_MAX_RESET = 16'd10000;

   // input item kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_PIN  = 1'b1;

   // trigger channels
   localparam logic [CH_W-1:0] CH_OPEN  = 2'd0;
   localparam logic [CH_W-1:0] CH_CLOSE = 2'd1;
   localparam logic [CH_W-1:0] CH_LIGHT = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE  = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_CLOSE = 2'd2,
      CMD_LIGHT = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      DOOR_UNKNOWN = 3'd0,
      DOOR_OPEN    = 3'd1,
      DOOR_CLOSED  = 3'd2,
      DOOR_OPENING = 3'd4,
      DOOR_CLOSING = 3'd5
   } door_type;

   typedef struct packed {
      logic            level_mode;
      logic [MS_W-1:0] holdoff_ms;
      logic [MS_W-1:0] lockout_ms;
      logic [MS_W-1:0] pulse_min_ms;
      logic [MS_W-1:0] pulse_max_ms;
   } cfg_type;

   typedef struct packed {
      logic            kind;
      logic [CH_W-1:0] channel;
      logic            level;
   } item_type;

   typedef struct packed {
      cmd_type  command;
      door_type door_status;
   } result_type;

endpackage

@@ sv/tpq_if.sv @@
// input channel: tick or pin change
interface tpq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [tpq_pkg::CH_W-1:0]      channel;
   logic                          level;

   modport source (output valid, kind, channel, level, input ready);
   modport sink (input valid, kind, channel, level, output ready);
endinterface

// result channel: command and door status
interface tpq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tpq_pkg::CMD_W-1:0]     command;
   logic [tpq_pkg::STATUS_W-1:0]  door_status;

   modport source (output valid, command, door_status, input ready);
   modport sink (input valid, command, door_status, output ready);
endinterface

// configuration write channel
interface tpq_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tpq_pkg::INDEX_W-1:0]   index;
   logic [tpq_pkg::MS_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/tpq_core.sv @@
// qualifier state and the per-item update
module tpq_core (
   input  logic                 clock,
   input  logic                 reset,
   input  tpq_pkg::cfg_type     cfg,
   input  logic                 step_en,
   input  tpq_pkg::item_type    item,
   output tpq_pkg::result_type  result
);

   logic [tpq_pkg::TIME_W-1:0] now_ff, now_in;
   logic                       done_ff, done_in;
   logic [tpq_pkg::TIME_W-1:0] edge_ff [3];
   logic [tpq_pkg::TIME_W-1:0] edge_in [3];
   logic [1:0]                 contact_ff, contact_in;
   logic [1:0]                 sampled_ff, sampled_in;
   logic [1:0]                 prev_ff, prev_in;
   tpq_pkg::door_type          door_ff, door_in;

   logic [tpq_pkg::TIME_W-1:0] edge_sel;
   logic [tpq_pkg::TIME_W-1:0] dt;
   logic                       pin_ok;
   logic                       pulse_ok;
   logic                       lock_ok;
   logic                       active;
   tpq_pkg::cmd_type           cmd;

   // time base and holdoff
   always_comb begin
      now_in  = now_ff + {{(tpq_pkg::TIME_W-1){1'b0}}, item.kind == tpq_pkg::KIND_TICK};
      done_in = done_ff ||
                (now_in >= {{(tpq_pkg::TIME_W-tpq_pkg::MS_W){1'b0}}, cfg.holdoff_ms});
      pin_ok  = (item.kind == tpq_pkg::KIND_PIN) && done_in;
      active  = !item.level;
   end

   // edge time of the addressed channel and distance to it
   always_comb begin
      case (item.channel)
         tpq_pkg::CH_OPEN:  edge_sel = edge_ff[0];
         tpq_pkg::CH_CLOSE: edge_sel = edge_ff[1];
         tpq_pkg::CH_LIGHT: edge_sel = edge_ff[2];
         default:           edge_sel = now_in;
      endcase
      dt       = now_in - edge_sel;
      pulse_ok = (dt > {{(tpq_pkg::TIME_W-tpq_pkg::MS_W){1'b0}}, cfg.pulse_min_ms}) &&
                 (dt < {{(tpq_pkg::TIME_W-tpq_pkg::MS_W){1'b0}}, cfg.pulse_max_ms});
      lock_ok  = dt > {{(tpq_pkg::TIME_W-tpq_pkg::MS_W){1'b0}}, cfg.lockout_ms};
   end

   // pulse qualification and level sampling
   always_comb begin
      edge_in    = edge_ff;
      contact_in = contact_ff;
      sampled_in = sampled_ff;
      cmd        = tpq_pkg::CMD_NONE;
      if (pin_ok) begin
         case (item.channel)
            tpq_pkg::CH_LIGHT: begin
               if (active) begin
                  edge_in[2] = now_in;
               end else if (pulse_ok) begin
                  cmd = tpq_pkg::CMD_LIGHT;
               end
            end
            tpq_pkg::CH_OPEN, tpq_pkg::CH_CLOSE: begin
               if (cfg.level_mode) begin
                  if (lock_ok) begin
                     contact_in[item.channel[0]] = active;
                     if (active != sampled_ff[item.channel[0]]) begin
                        edge_in[item.channel] = now_in;
                        sampled_in[item.channel[0]] = active;
                     end
                  end
               end else if (active) begin
                  edge_in[item.channel] = now_in;
               end else if (pulse_ok) begin
                  cmd = item.channel[0] ? tpq_pkg::CMD_CLOSE : tpq_pkg::CMD_OPEN;
               end
            end
            default: begin
               cmd = tpq_pkg::CMD_NONE;
            end
         endcase
      end
   end

   // door status from the contact flags, level mode only
   always_comb begin
      door_in = door_ff;
      prev_in = prev_ff;
      if (cfg.level_mode) begin
         if (contact_in[0]) door_in = tpq_pkg::DOOR_OPEN;
         if (contact_in[1]) door_in = tpq_pkg::DOOR_CLOSED;
         if (contact_in == 2'b00) begin
            if (prev_ff[1]) door_in = tpq_pkg::DOOR_OPENING;
            if (prev_ff[0]) door_in = tpq_pkg::DOOR_CLOSING;
         end
         prev_in = contact_in;
      end
      result.command     = cmd;
      result.door_status = door_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff     <= '0;
         done_ff    <= 1'b0;
         contact_ff <= '0;
         sampled_ff <= '0;
         prev_ff    <= '0;
         door_ff    <= tpq_pkg::DOOR_UNKNOWN;
         for (int i = 0; i < 3; i++) begin
            edge_ff[i] <= '0;
         end
      end else if (step_en) begin
         now_ff     <= now_in;
         done_ff    <= done_in;
         contact_ff <= contact_in;
         sampled_ff <= sampled_in;
         prev_ff    <= prev_in;
         door_ff    <= door_in;
         for (int i = 0; i < 3; i++) begin
            edge_ff[i] <= edge_in[i];
         end
      end
   end

endmodule

@@ sv/trigger_pulse_qualifier.sv @@
// trigger pulse qualifier
// req_bus carries one transaction per 1 ms tick (kind 0) or per pin change
// (kind 1) on the open, close or light trigger, with the pin level after it.
// rsp_bus returns exactly one transaction per request: the qualified command
// (none, open, close, toggle light) and the current door status.
// csr_bus writes the five configuration registers by index; it is always
// ready and should only be written while no request is in flight.
// a request accepted into the input register passes through the core to
// the result register, which presents its result on rsp_bus; all qualification
// compares and the door status logic sit between those two registers.
// throughput: one request per cycle while rsp_bus does not stall.
// when rsp_bus stalls the result register holds, the input register takes
// one more request, and req_bus.ready then drops until the result drains.
// reset clears the time counter, holdoff, edge times, contact flags and
// door status (unknown), restores the register defaults and empties both
// pipeline registers.
module trigger_pulse_qualifier (
   input  logic          clock,
   input  logic          reset,
   tpq_req_if.sink       req_bus,
   tpq_rsp_if.source     rsp_bus,
   tpq_csr_if.sink       csr_bus
);

   tpq_pkg::cfg_type     cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   tpq_pkg::item_type    in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   tpq_pkg::result_type  out_res_ff;
   tpq_pkg::result_type  step_res;
   logic                 advance;
   logic                 req_take;

   // configuration writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            tpq_pkg::REG_LEVEL_MODE:   cfg_in.level_mode   = csr_bus.data[0];
            tpq_pkg::REG_HOLDOFF_MS:   cfg_in.holdoff_ms   = csr_bus.data;
            tpq_pkg::REG_LOCKOUT_MS:   cfg_in.lockout_ms   = csr_bus.data;
            tpq_pkg::REG_PULSE_MIN_MS: cfg_in.pulse_min_ms = csr_bus.data;
            tpq_pkg::REG_PULSE_MAX_MS: cfg_in.pulse_max_ms = csr_bus.data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // pipeline handshake
   always_comb begin
      advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
      req_bus.ready = !in_valid_ff || advance;
      req_take      = req_bus.valid && req_bus.ready;
      in_valid_in   = req_take || (in_valid_ff && !advance);
      out_valid_in  = advance || (out_valid_ff && !rsp_bus.ready);
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.command     = out_res_ff.command;
   assign rsp_bus.door_status = out_res_ff.door_status;

   tpq_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (step_res)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_mode   <= 1'b0;
         cfg_ff.holdoff_ms   <= tpq_pkg::HOLDOFF_RESET;
         cfg_ff.lockout_ms   <= tpq_pkg::LOCKOUT_RESET;
         cfg_ff.pulse_min_ms <= tpq_pkg::PULSE_MIN_RESET;
         cfg_ff.pulse_max_ms <= tpq_pkg::PULSE_MAX_RESET;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind    <= req_bus.kind;
         in_item_ff.channel <= req_bus.channel;
         in_item_ff.level   <= req_bus.level;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

endmodule

@@ sv/tpq_checker.sv @@
`include "trigger_pulse_qualifier_assert.svh"

// port-level checks for the trigger pulse qualifier
module tpq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tpq_pkg::CMD_W-1:0]     rsp_command,
   input logic [tpq_pkg::STATUS_W-1:0]  rsp_door_status
);

   logic [1:0] pending_ff, pending_in;
   logic       req_xfer;
   logic       rsp_xfer;
   logic       rsp_stall;
   logic       full_stall;
   logic       status_ok;
   logic [tpq_pkg::CMD_W+tpq_pkg::STATUS_W-1:0] rsp_payload;

   // transactions accepted but not yet returned
   always_comb begin
      req_xfer    = req_valid && req_ready;
      rsp_xfer    = rsp_valid && rsp_ready;
      pending_in  = pending_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
      rsp_stall   = rsp_valid && !rsp_ready;
      full_stall  = (pending_ff == 2'd2) && !rsp_ready;
      rsp_payload = {rsp_command, rsp_door_status};
      status_ok   = (rsp_door_status == tpq_pkg::DOOR_UNKNOWN) ||
                    (rsp_door_status == tpq_pkg::DOOR_OPEN) ||
                    (rsp_door_status == tpq_pkg::DOOR_CLOSED) ||
                    (rsp_door_status == tpq_pkg::DOOR_OPENING) ||
                    (rsp_door_status == tpq_pkg::DOOR_CLOSING);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled result holds its value
   `TPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // door status is one of the defined codes
   `TPQ_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, status_ok)

   // no result without an outstanding request
   `TPQ_ASSERT_NOW(a_no_spurious, clock, reset, rsp_valid, pending_ff != 2'd0)

   // both registers full and the receiver stalled: no new request
   `TPQ_ASSERT_NOW(a_depth, clock, reset, full_stall, !req_ready)

endmodule

bind trigger_pulse_qualifier tpq_checker u_tpq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_command     (rsp_bus.command),
   .rsp_door_status (rsp_bus.door_status)
);

@@ dv/tb_trigger_pulse_qualifier.sv @@
module tb_trigger_pulse_qualifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [tpq_pkg::CH_W-1:0] CH_UNUSED = 2'd3;
   localparam int NUM_DIRECTED = 36;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 140;
   localparam int LONG_HOLD = 80;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct {
      bit                          is_write;
      logic [tpq_pkg::INDEX_W-1:0] index;
      logic [tpq_pkg::MS_W-1:0]    data;
      tpq_pkg::item_type           it;
      bit                          typed;
      tpq_pkg::result_type         want;
   } step_row_type;

   logic clock;
   logic reset;

   tpq_req_if req_bus ();
   tpq_rsp_if rsp_bus ();
   tpq_csr_if csr_bus ();

   trigger_pulse_qualifier i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // qualifier state mirrored by the testbench
   tpq_pkg::cfg_type  cfg = '{1'b0, tpq_pkg::HOLDOFF_RESET, tpq_pkg::LOCKOUT_RESET,
                             tpq_pkg::PULSE_MIN_RESET, tpq_pkg::PULSE_MAX_RESET};
   logic [tpq_pkg::TIME_W-1:0] ms_now = '0;
   bit                         holdoff_over = 1'b0;
   logic [tpq_pkg::TIME_W-1:0] mark_ms [3] = '{default: '0};
   bit                         contact [2] = '{default: 1'b0};
   bit                         sampled [2] = '{default: 1'b0};
   bit                         prev_contact [2] = '{default: 1'b0};
   tpq_pkg::door_type          door = tpq_pkg::DOOR_UNKNOWN;

   // expected command and status, oldest first
   tpq_pkg::result_type cmd_status_q [$];

   int           miscompares = 0;
   int           items_sent = 0;
   int           burst_left = 0;
   int           long_holds_asked = 0;
   longint       cycle_count = 0;
   step_row_type directed_steps [NUM_DIRECTED];

   // pulse width qualification on one channel
   function automatic tpq_pkg::cmd_type pulse_command(logic [tpq_pkg::CH_W-1:0] ch, logic lvl,
                                                      tpq_pkg::cmd_type hit);
      logic [tpq_pkg::TIME_W-1:0] width;
      if (lvl == 1'b0) begin
         mark_ms[ch] = ms_now;
         return tpq_pkg::CMD_NONE;
      end
      width = ms_now - mark_ms[ch];
      if (width > {16'd0, cfg.pulse_min_ms} && width < {16'd0, cfg.pulse_max_ms})
         return hit;
      return tpq_pkg::CMD_NONE;
   endfunction

   // one tick or pin change through the qualifier
   task automatic qualify_trigger(input tpq_pkg::item_type it, output tpq_pkg::result_type r);
      tpq_pkg::cmd_type           cmd;
      logic [tpq_pkg::TIME_W-1:0] since;
      bit                         c;
      cmd = tpq_pkg::CMD_NONE;
      c = it.channel[0];
      if (it.kind == tpq_pkg::KIND_TICK)
         ms_now = ms_now + 32'd1;
      if (!holdoff_over && ms_now >= {16'd0, cfg.holdoff_ms})
         holdoff_over = 1'b1;
      if (it.kind == tpq_pkg::KIND_PIN && holdoff_over) begin
         if (it.channel == tpq_pkg::CH_LIGHT) begin
            cmd = pulse_command(tpq_pkg::CH_LIGHT, it.level, tpq_pkg::CMD_LIGHT);
         end else if (it.channel == tpq_pkg::CH_OPEN || it.channel == tpq_pkg::CH_CLOSE) begin
            if (cfg.level_mode) begin
               // level sample with lockout
               since = ms_now - mark_ms[it.channel];
               if (since > {16'd0, cfg.lockout_ms}) begin
                  contact[c] = ~it.level;
                  if (contact[c] != sampled[c]) begin
                     mark_ms[it.channel] = ms_now;
                     sampled[c] = contact[c];
                  end
               end
            end else begin
               cmd = pulse_command(it.channel, it.level,
                                   (it.channel == tpq_pkg::CH_OPEN) ? tpq_pkg::CMD_OPEN
                                                                    : tpq_pkg::CMD_CLOSE);
            end
         end
      end
      // door status from contacts, close wins, closing wins
      if (cfg.level_mode) begin
         if (contact[0]) door = tpq_pkg::DOOR_OPEN;
         if (contact[1]) door = tpq_pkg::DOOR_CLOSED;
         if (!contact[0] && !contact[1]) begin
            if (prev_contact[1]) door = tpq_pkg::DOOR_OPENING;
            if (prev_contact[0]) door = tpq_pkg::DOOR_CLOSING;
         end
         prev_contact[0] = contact[0];
         prev_contact[1] = contact[1];
      end
      r.command = cmd;
      r.door_status = door;
   endtask

   function automatic tpq_pkg::item_type tick_item();
      tpq_pkg::item_type it;
      it.kind = tpq_pkg::KIND_TICK;
      it.channel = 2'($urandom_range(0, 3));
      it.level = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic tpq_pkg::item_type pin_item(logic [tpq_pkg::CH_W-1:0] ch, logic lvl);
      tpq_pkg::item_type it;
      it.kind = tpq_pkg::KIND_PIN;
      it.channel = ch;
      it.level = lvl;
      return it;
   endfunction

   function automatic step_row_type item_row(logic kind, logic [tpq_pkg::CH_W-1:0] ch,
                                             logic lvl);
      step_row_type r;
      r.is_write = 1'b0;
      r.index = tpq_pkg::REG_LEVEL_MODE;
      r.data = '0;
      r.it.kind = kind;
      r.it.channel = ch;
      r.it.level = lvl;
      r.typed = 1'b0;
      r.want.command = tpq_pkg::CMD_NONE;
      r.want.door_status = tpq_pkg::DOOR_UNKNOWN;
      return r;
   endfunction

   // transaction that must give no command and unknown status
   function automatic step_row_type quiet_row(logic kind, logic [tpq_pkg::CH_W-1:0] ch,
                                              logic lvl);
      step_row_type r;
      r = item_row(kind, ch, lvl);
      r.typed = 1'b1;
      return r;
   endfunction

   function automatic step_row_type reg_row(logic [tpq_pkg::INDEX_W-1:0] idx,
                                            logic [tpq_pkg::MS_W-1:0] val);
      step_row_type r;
      r = item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0);
      r.is_write = 1'b1;
      r.index = idx;
      r.data = val;
      return r;
   endfunction

   // offer one transaction, predict it, then pace the burst
   task automatic offer_item(input tpq_pkg::item_type it, input bit typed,
                             input tpq_pkg::result_type want);
      tpq_pkg::result_type r;
      int                  gap;
      req_bus.valid <= 1'b1;
      req_bus.kind <= it.kind;
      req_bus.channel <= it.channel;
      req_bus.level <= it.level;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      qualify_trigger(it, r);
      cmd_status_q.push_back(typed ? want : r);
      items_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic offer_ticks(input int n);
      repeat (n) offer_item(tick_item(), 1'b0, '0);
   endtask

   // wait for every expected transaction, then let the pipeline empty
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (cmd_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tpq_pkg::INDEX_W-1:0] idx,
                            input logic [tpq_pkg::MS_W-1:0] val, input bit last);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         tpq_pkg::REG_LEVEL_MODE:   cfg.level_mode = val[0];
         tpq_pkg::REG_HOLDOFF_MS:   cfg.holdoff_ms = val;
         tpq_pkg::REG_LOCKOUT_MS:   cfg.lockout_ms = val;
         tpq_pkg::REG_PULSE_MIN_MS: cfg.pulse_min_ms = val;
         tpq_pkg::REG_PULSE_MAX_MS: cfg.pulse_max_ms = val;
         default: ;
      endcase
      if (last)
         csr_bus.valid <= 1'b0;
   endtask

   // pulses sized around the current window, overlaps and noise
   task automatic offer_sequence();
      int                          span;
      int                          pick;
      logic [tpq_pkg::CH_W-1:0] a;
      logic [tpq_pkg::CH_W-1:0] b;
      span = cfg.level_mode ? int'(cfg.lockout_ms) : int'(cfg.pulse_max_ms);
      if (span > 14)
         span = 14;
      span = span + 2;
      pick = $urandom_range(0, 9);
      a = 2'($urandom_range(0, 2));
      b = 2'($urandom_range(0, 2));
      if (pick < 5) begin
         offer_item(pin_item(a, 1'b0), 1'b0, '0);
         offer_ticks($urandom_range(0, span));
         offer_item(pin_item(a, 1'b1), 1'b0, '0);
         offer_ticks($urandom_range(0, 3));
      end else if (pick < 7) begin
         offer_item(pin_item(a, 1'b0), 1'b0, '0);
         offer_ticks($urandom_range(0, span / 2));
         offer_item(pin_item(b, 1'b0), 1'b0, '0);
         offer_ticks($urandom_range(0, span / 2));
         offer_item(pin_item(a, 1'b1), 1'b0, '0);
         offer_ticks($urandom_range(0, span / 2));
         offer_item(pin_item(b, 1'b1), 1'b0, '0);
      end else begin
         offer_item(pin_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))), 1'b0, '0);
         offer_ticks($urandom_range(0, 2));
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result receiver: own stall pattern plus requested long hold-offs
   initial begin
      int holds_served;
      int stall_left;
      int mode;
      int mode_left;
      holds_served = 0;
      stall_left = 0;
      mode = 0;
      mode_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (holds_served != long_holds_asked) begin
            holds_served++;
            stall_left = LONG_HOLD;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      tpq_pkg::result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (cmd_status_q.size() == 0) begin
            if (miscompares < SHOWN_MISMATCHES)
               $display("unexpected transaction: command %0d status %0d",
                        rsp_bus.command, rsp_bus.door_status);
            miscompares++;
         end else begin
            want = cmd_status_q.pop_front();
            if (rsp_bus.command !== want.command ||
                rsp_bus.door_status !== want.door_status) begin
               if (miscompares < SHOWN_MISMATCHES)
                  $display("mismatch: command exp %0d got %0d, status exp %0d got %0d",
                           want.command, rsp_bus.command, want.door_status,
                           rsp_bus.door_status);
               miscompares++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      tpq_pkg::cfg_type next;
      int               phase_start;
      bit               held;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = tpq_pkg::KIND_TICK;
      req_bus.channel = tpq_pkg::CH_OPEN;
      req_bus.level = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = tpq_pkg::REG_LEVEL_MODE;
      csr_bus.data = '0;

      directed_steps = '{
         // boot holdoff: edges ignored
         quiet_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b0),
         quiet_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_LIGHT, 1'b1),
         quiet_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0),
         // holdoff ends, widest pulse window
         reg_row(tpq_pkg::REG_HOLDOFF_MS, 16'd0),
         reg_row(tpq_pkg::REG_PULSE_MIN_MS, 16'd0),
         reg_row(tpq_pkg::REG_PULSE_MAX_MS, 16'hFFFF),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_LIGHT, 1'b0),
         item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_LIGHT, 1'b1),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b1),
         // unused channel ignored
         quiet_row(tpq_pkg::KIND_PIN, CH_UNUSED, 1'b0),
         quiet_row(tpq_pkg::KIND_PIN, CH_UNUSED, 1'b1),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_CLOSE, 1'b0),
         item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_CLOSE, 1'b1),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_CLOSE, 1'b1),
         // empty window
         reg_row(tpq_pkg::REG_PULSE_MIN_MS, 16'hFFFF),
         reg_row(tpq_pkg::REG_PULSE_MAX_MS, 16'd0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_TICK, CH_UNUSED, 1'b1),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b1),
         // level mode, no lockout, holdoff rewrite has no effect
         reg_row(tpq_pkg::REG_LOCKOUT_MS, 16'd0),
         reg_row(tpq_pkg::REG_LEVEL_MODE, 16'd1),
         reg_row(tpq_pkg::REG_HOLDOFF_MS, 16'hFFFF),
         item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_CLOSE, 1'b0),
         item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_CLOSE, 1'b1),
         item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b1),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_OPEN, 1'b0),
         // longest lockout blocks samples
         reg_row(tpq_pkg::REG_LOCKOUT_MS, 16'hFFFF),
         item_row(tpq_pkg::KIND_TICK, tpq_pkg::CH_OPEN, 1'b0),
         item_row(tpq_pkg::KIND_PIN, tpq_pkg::CH_CLOSE, 1'b0)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_steps[i].is_write) begin
            if (i == 0 || !directed_steps[i-1].is_write)
               settle();
            write_reg(directed_steps[i].index, directed_steps[i].data,
                      (i == NUM_DIRECTED - 1) || !directed_steps[i+1].is_write);
         end else begin
            offer_item(directed_steps[i].it, directed_steps[i].typed, directed_steps[i].want);
         end
      end

      // random phases, each with its own register setting
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         next.level_mode = 1'b0;
         next.holdoff_ms = 16'($urandom_range(0, 65535));
         next.lockout_ms = 16'($urandom_range(0, 6));
         next.pulse_min_ms = 16'($urandom_range(0, 6));
         next.pulse_max_ms = 16'(next.pulse_min_ms + $urandom_range(1, 10));
         case (phase)
            1, 6: begin
               next.level_mode = 1'b1;
               if (phase == 6)
                  next.lockout_ms = 16'd0;
            end
            2: begin
               next.pulse_min_ms = 16'd0;
               next.pulse_max_ms = 16'hFFFF;
            end
            3: begin
               next.level_mode = 1'b1;
               next.lockout_ms = 16'hFFFF;
            end
            4: begin
               next.pulse_min_ms = 16'hFFFF;
               next.pulse_max_ms = 16'd0;
            end
            5: begin
               next.level_mode = 1'($urandom_range(0, 1));
               next.lockout_ms = 16'($urandom_range(0, 65535));
               next.pulse_min_ms = 16'($urandom_range(0, 65535));
               next.pulse_max_ms = 16'($urandom_range(0, 65535));
            end
            7: begin
               next.pulse_min_ms = 16'($urandom_range(0, 3));
               next.pulse_max_ms = 16'($urandom_range(0, 8));
            end
            default: ;
         endcase
         write_reg(tpq_pkg::REG_LEVEL_MODE, {15'd0, next.level_mode}, 1'b0);
         write_reg(tpq_pkg::REG_HOLDOFF_MS, next.holdoff_ms, 1'b0);
         write_reg(tpq_pkg::REG_LOCKOUT_MS, next.lockout_ms, 1'b0);
         write_reg(tpq_pkg::REG_PULSE_MIN_MS, next.pulse_min_ms, 1'b0);
         write_reg(tpq_pkg::REG_PULSE_MAX_MS, next.pulse_max_ms, 1'b1);
         phase_start = items_sent;
         held = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // long receiver hold-off while transactions keep coming
            if (!held && (phase == 1 || phase == 5) && items_sent - phase_start >= 40) begin
               long_holds_asked++;
               held = 1'b1;
            end
            offer_sequence();
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (miscompares == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tpq_pkg.sv
sv/tpq_if.sv
sv/tpq_core.sv
sv/trigger_pulse_qualifier.sv
sv/tpq_checker.sv
dv/tb_trigger_pulse_qualifier.sv
